/* sv/cfle_pkg.sv */
// Shared types, constants and helpers for the channel frame link engine.
// No dependencies; every other file refers to this package by scoped names.
package cfle_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int MAX_PAYLOAD  = 32;
    localparam int CTRL_LEN     = 8;

    localparam int LEN_W   = 6;
    localparam int IDX_W   = $clog2(MAX_PAYLOAD);
    localparam int BANK_W  = 3;
    localparam int ADDR_W  = BANK_W + IDX_W;
    localparam int JOB_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [2:0] REG_LENGTHS  = 3'd0;
    localparam logic [2:0] REG_PER_UNS  = 3'd1;
    localparam logic [2:0] REG_PER_SYN  = 3'd2;
    localparam logic [2:0] REG_SYNC     = 3'd3;
    localparam logic [2:0] REG_ACK_CODE = 3'd4;

    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;

    typedef enum logic [1:0] {
        PH_CHAN    = 2'd0,
        PH_CHECK   = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_rx_phase;

    typedef struct packed {
        logic [63:0] lengths;
        logic [31:0] per_uns;
        logic [31:0] per_syn;
        logic [7:0]  sync_code;
        logic [7:0]  ack_code;
    } t_cfg;

    typedef struct packed {
        logic              is_tick;
        logic [2:0]        ch;
        logic [LEN_W-1:0]  len;
        logic [BANK_W-1:0] bank;
        logic              synced;
        logic [31:0]       now;
        logic [7:0]        cks;
        logic [7:0]        code;
    } t_job;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic [2:0] ch;
        logic       last;
        logic       synced;
    } t_res;

    // (acc + b) mod 255 for acc below 255
    function automatic logic [7:0] add_mod255(input logic [7:0] acc, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, acc} + {1'b0, b};
        if (s >= 9'd255) s = s - 9'd255;
        return s[7:0];
    endfunction

    function automatic logic [7:0] sync_cks(input logic [7:0] code, input logic [31:0] now);
        logic [10:0] s;
        logic [8:0]  f;
        s = {3'b0, code} + {3'b0, now[31:24]} + {3'b0, now[23:16]}
            + {3'b0, now[15:8]} + {3'b0, now[7:0]};
        f = {1'b0, s[7:0]} + {6'b0, s[10:8]};
        if (f >= 9'd255) f = f - 9'd255;
        return f[7:0];
    endfunction

endpackage

/* sv/cfle_job_fifo.sv */
// Short job queue between the frame front end and the output back end.
// Depends on cfle_pkg.
module cfle_job_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cfle_pkg::t_job    i_job,
    input  logic              i_pop,
    output cfle_pkg::t_job    o_job,
    output logic              o_empty,
    output logic              o_full
);
    localparam int PW = $clog2(cfle_pkg::JOB_DEPTH);

    cfle_pkg::t_job r_mem [cfle_pkg::JOB_DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [PW:0]    r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PW+1)'(cfle_pkg::JOB_DEPTH));
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
endmodule

/* sv/cfle_front.sv */
// Front end: deframes received bytes, checks frames, runs the heartbeat
// and queues output jobs. Depends on cfle_pkg.
module cfle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_action,
    input  logic [7:0]          i_rx_byte,
    input  logic [31:0]         i_now_ms,
    input  cfle_pkg::t_cfg      i_cfg,
    output logic                o_job_push,
    output cfle_pkg::t_job      o_job,
    output cfle_pkg::t_mem_wr   o_mem_wr
);
    localparam int LW = cfle_pkg::LEN_W;

    cfle_pkg::t_rx_phase r_phase, n_phase;
    logic [2:0]    r_chan, n_chan;
    logic          r_chan_ok, n_chan_ok;
    logic [7:0]    r_check, n_check;
    logic [7:0]    r_acc, n_acc;
    logic [LW-1:0] r_count, n_count;
    logic [LW-1:0] r_len, n_len;
    logic [cfle_pkg::BANK_W-1:0] r_bank, n_bank;
    logic          r_synced, n_synced;
    logic [31:0]   r_sent, n_sent;
    logic [31:0]   r_answered, n_answered;
    logic [7:0]    r_ctrl [5];

    logic [7:0]    len_raw;
    logic [LW-1:0] len_clamp;
    logic [7:0]    p [5];
    logic [31:0]   period;

    always_comb begin
        len_raw   = i_cfg.lengths[r_chan*8 +: 8];
        len_clamp = (len_raw > 8'(cfle_pkg::MAX_PAYLOAD)) ? LW'(cfle_pkg::MAX_PAYLOAD)
                                                          : len_raw[LW-1:0];
        for (int i = 0; i < 5; i++) begin
            p[i] = (r_count == LW'(i)) ? i_rx_byte : r_ctrl[i];
        end
        period = r_synced ? i_cfg.per_syn : i_cfg.per_uns;
    end

    always_comb begin
        n_phase    = r_phase;
        n_chan     = r_chan;
        n_chan_ok  = r_chan_ok;
        n_check    = r_check;
        n_acc      = r_acc;
        n_count    = r_count;
        n_len      = r_len;
        n_bank     = r_bank;
        n_synced   = r_synced;
        n_sent     = r_sent;
        n_answered = r_answered;
        o_job_push = 1'b0;
        o_job      = '{is_tick: 1'b0, ch: r_chan, len: r_len, bank: r_bank,
                       synced: r_synced, now: i_now_ms,
                       cks: cfle_pkg::sync_cks(i_cfg.sync_code, i_now_ms),
                       code: i_cfg.sync_code};
        o_mem_wr   = '{en: 1'b0, addr: {r_bank, r_count[cfle_pkg::IDX_W-1:0]},
                       data: i_rx_byte};
        if (i_valid) begin
            if (i_action) begin
                if ((i_now_ms - r_sent) >= period) begin
                    n_synced     = r_synced && (r_sent == r_answered);
                    n_sent       = i_now_ms;
                    o_job_push   = 1'b1;
                    o_job.is_tick = 1'b1;
                    o_job.ch     = 3'd0;
                    o_job.len    = LW'(cfle_pkg::CTRL_LEN + 2);
                    o_job.synced = n_synced;
                end
            end else begin
                unique case (r_phase)
                    cfle_pkg::PH_CHECK: begin
                        n_check = i_rx_byte;
                        if (!r_chan_ok || len_clamp == '0) begin
                            n_phase = cfle_pkg::PH_CHAN;
                        end else begin
                            n_phase = cfle_pkg::PH_PAYLOAD;
                            n_count = '0;
                            n_acc   = {5'b0, r_chan};
                            n_len   = len_clamp;
                        end
                    end
                    cfle_pkg::PH_PAYLOAD: begin
                        o_mem_wr.en = 1'b1;
                        n_acc   = cfle_pkg::add_mod255(r_acc, i_rx_byte);
                        n_count = r_count + 1'b1;
                        if (n_count == r_len) begin
                            n_phase = cfle_pkg::PH_CHAN;
                            if (n_acc == r_check) begin
                                if (r_chan == 3'd0) begin
                                    if (p[0] == i_cfg.ack_code &&
                                        {p[1], p[2], p[3], p[4]} == r_sent) begin
                                        n_answered = r_sent;
                                        n_synced   = 1'b1;
                                    end
                                end else begin
                                    o_job_push = 1'b1;
                                    n_bank     = r_bank + 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        n_chan    = i_rx_byte[2:0];
                        n_chan_ok = i_rx_byte < 8'(cfle_pkg::NUM_CHANNELS);
                        n_phase   = cfle_pkg::PH_CHECK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cfle_pkg::PH_CHAN;
            r_chan     <= '0;
            r_chan_ok  <= 1'b0;
            r_check    <= '0;
            r_acc      <= '0;
            r_count    <= '0;
            r_len      <= '0;
            r_bank     <= '0;
            r_synced   <= 1'b0;
            r_sent     <= '0;
            r_answered <= '0;
        end else begin
            r_phase    <= n_phase;
            r_chan     <= n_chan;
            r_chan_ok  <= n_chan_ok;
            r_check    <= n_check;
            r_acc      <= n_acc;
            r_count    <= n_count;
            r_len      <= n_len;
            r_bank     <= n_bank;
            r_synced   <= n_synced;
            r_sent     <= n_sent;
            r_answered <= n_answered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mem_wr.en && r_count < LW'(5)) r_ctrl[r_count[2:0]] <= i_rx_byte;
    end
endmodule

/* sv/cfle_back.sv */
// Back end: payload store, burst sequencer and result queue.
// Depends on cfle_pkg.
module cfle_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cfle_pkg::t_mem_wr  i_mem_wr,
    input  cfle_pkg::t_job     i_job,
    input  logic               i_job_valid,
    output logic               o_job_pop,
    input  logic               i_pop,
    output cfle_pkg::t_res     o_res,
    output logic               o_empty
);
    localparam int LW = cfle_pkg::LEN_W;
    localparam int OW = $clog2(cfle_pkg::OUT_DEPTH);

    logic [7:0]    r_store [2**cfle_pkg::ADDR_W];
    logic [7:0]    r_rd;
    logic [LW-1:0] r_idx;
    logic          r_s1_valid;
    cfle_pkg::t_res r_s1;
    cfle_pkg::t_res r_q [cfle_pkg::OUT_DEPTH];
    logic [OW-1:0] r_wp, r_rp;
    logic [OW:0]   r_cnt;

    logic          issue, last, deq;
    logic [7:0]    tx_byte;
    cfle_pkg::t_res s2;

    assign issue = i_job_valid &&
                   ((r_cnt + (OW+1)'(r_s1_valid)) < (OW+1)'(cfle_pkg::OUT_DEPTH));
    assign last      = (r_idx + 1'b1) == i_job.len;
    assign o_job_pop = issue && last;
    assign o_empty   = (r_cnt == '0);
    assign deq       = i_pop && !o_empty;
    assign o_res     = r_q[r_rp];

    always_comb begin
        if (r_idx == LW'(0))      tx_byte = 8'd0;
        else if (r_idx == LW'(1)) tx_byte = i_job.cks;
        else if (r_idx == LW'(2)) tx_byte = i_job.code;
        else if (r_idx == LW'(3)) tx_byte = i_job.now[31:24];
        else if (r_idx == LW'(4)) tx_byte = i_job.now[23:16];
        else if (r_idx == LW'(5)) tx_byte = i_job.now[15:8];
        else if (r_idx == LW'(6)) tx_byte = i_job.now[7:0];
        else                      tx_byte = 8'd0;
        s2 = r_s1;
        if (r_s1.kind == cfle_pkg::KIND_RX) s2.data = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) r_store[i_mem_wr.addr] <= i_mem_wr.data;
        r_rd <= r_store[{i_job.bank, r_idx[cfle_pkg::IDX_W-1:0]}];
        if (issue) begin
            r_s1 <= '{kind: i_job.is_tick ? cfle_pkg::KIND_TX : cfle_pkg::KIND_RX,
                      data: tx_byte, ch: i_job.ch, last: last, synced: i_job.synced};
        end
        if (r_s1_valid) r_q[r_wp] <= s2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_wp       <= '0;
            r_rp       <= '0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= issue;
            if (issue) r_idx <= last ? '0 : r_idx + 1'b1;
            if (r_s1_valid) r_wp <= r_wp + 1'b1;
            if (deq) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (OW+1)'(r_s1_valid) - (OW+1)'(deq);
        end
    end
endmodule

/* sv/channel_frame_link_engine_top.sv */
// Top level of the channel frame link engine: config registers and wiring.
// Depends on cfle_pkg, cfle_front, cfle_job_fifo and cfle_back.
// One item is taken per clock while the job queue has room; a data frame of
// N payload bytes gives N results and a heartbeat gives CTRL_LEN+2 results,
// one result per clock from the back end while its result queue has room,
// so full rises when bursts outrun the back end. Registers sit at 8*i.
module channel_frame_link_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic        i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_now_ms,
    output logic        empty,
    input  logic        pop,
    output logic        o_kind,
    output logic [7:0]  o_data,
    output logic [2:0]  o_channel,
    output logic        o_last,
    output logic        o_synced
);
    cfle_pkg::t_cfg    r_cfg;
    cfle_pkg::t_job    job_in, job_out;
    cfle_pkg::t_mem_wr mem_wr;
    cfle_pkg::t_res    res;
    logic job_push, job_pop, job_empty, job_full, accept;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign full    = job_full;
    assign accept  = push && !job_full;

    always_comb begin
        unique case (reg_idx)
            cfle_pkg::REG_LENGTHS:  prdata = r_cfg.lengths;
            cfle_pkg::REG_PER_UNS:  prdata = {32'd0, r_cfg.per_uns};
            cfle_pkg::REG_PER_SYN:  prdata = {32'd0, r_cfg.per_syn};
            cfle_pkg::REG_SYNC:     prdata = {56'd0, r_cfg.sync_code};
            cfle_pkg::REG_ACK_CODE: prdata = {56'd0, r_cfg.ack_code};
            default:                prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{lengths: 64'd8, per_uns: 32'd1000, per_syn: 32'd5000,
                       sync_code: 8'd0, ack_code: 8'd1};
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                cfle_pkg::REG_LENGTHS:  r_cfg.lengths   <= pwdata;
                cfle_pkg::REG_PER_UNS:  r_cfg.per_uns   <= pwdata[31:0];
                cfle_pkg::REG_PER_SYN:  r_cfg.per_syn   <= pwdata[31:0];
                cfle_pkg::REG_SYNC:     r_cfg.sync_code <= pwdata[7:0];
                cfle_pkg::REG_ACK_CODE: r_cfg.ack_code  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    cfle_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept), .i_action(i_action),
        .i_rx_byte(i_rx_byte), .i_now_ms(i_now_ms), .i_cfg(r_cfg),
        .o_job_push(job_push), .o_job(job_in), .o_mem_wr(mem_wr)
    );

    cfle_job_fifo u_jobs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(job_push), .i_job(job_in),
        .i_pop(job_pop), .o_job(job_out), .o_empty(job_empty), .o_full(job_full)
    );

    cfle_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mem_wr(mem_wr), .i_job(job_out),
        .i_job_valid(!job_empty), .o_job_pop(job_pop), .i_pop(pop),
        .o_res(res), .o_empty(empty)
    );

    assign o_kind    = res.kind;
    assign o_data    = res.data;
    assign o_channel = res.ch;
    assign o_last    = res.last;
    assign o_synced  = res.synced;

    a_no_job_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_full |-> !job_push) else $error("job queue overflow");
    a_tx_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == cfle_pkg::KIND_TX) |-> o_channel == 3'd0)
        else $error("transmit byte on nonzero channel");
    a_pop_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !job_empty) else $error("job pop while queue empty");
endmodule
